### src/mlcd_pkg.sv
package mlcd_pkg;

  // Panel geometry.
  localparam int LINES          = 96;
  localparam int BYTES_PER_LINE = 12;
  localparam int STORE_DEPTH    = LINES * BYTES_PER_LINE;

  // Store address, sweep bound, line counter and slot counter widths.
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int LN_W   = $clog2(LINES + 1);
  localparam int SLOT_W = $clog2(BYTES_PER_LINE + 2);

  // Fixed bytes of the serial protocol.
  localparam logic [7:0] BYTE_UPDATE = 8'h80;
  localparam logic [7:0] BYTE_CLEAR  = 8'h20;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_CLEAR_ALL   = 2'd1,
    CMD_CLEAR_RANGE = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_TICK,
    ST_CLR_HEAD,
    ST_CLR_TAIL
  } state_t;

  // Position within the refresh frame: opening byte, line slots, closing byte.
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_BODY,
    PH_TAIL
  } phase_t;

  // Access to the frame store from the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // Mirror all eight bits of a byte.
  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[7-b] = v[b];
    end
    return r;
  endfunction

endpackage

### src/mlcd_store.sv
module mlcd_store import mlcd_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/mlcd_ctrl.sv
module mlcd_ctrl import mlcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_line,
  input  logic [3:0]  in_column,
  input  logic [7:0]  in_data,
  input  logic [6:0]  in_stop_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_spi_byte,
  output logic        out_frame_start,
  output logic        out_last,
  output store_req_t  store_req,
  input  logic [7:0]  store_rdata
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [CNT_W-1:0]  sweep_end_r, sweep_end_nxt;
  phase_t            phase_r, phase_nxt;
  logic [LN_W-1:0]   ln_r, ln_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W-1:0] frm_addr_r, frm_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_fs_r;
  logic              out_last_r;

  cmd_t              cmd;
  logic              out_free;
  logic              load;
  logic [7:0]        ld_byte;
  logic              ld_fs;
  logic              ld_last;
  logic              wr_in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic [LN_W-1:0]   stop_lim;

  assign cmd      = cmd_t'(in_command);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Decode of a byte write and of a clear range.
  always_comb begin
    wr_in_range = (int'(in_line) < LINES) && (int'(in_column) < BYTES_PER_LINE);
    wr_addr     = ADDR_W'(int'(in_line) * BYTES_PER_LINE + int'(in_column));
    if (int'(in_stop_line) > LINES) begin
      stop_lim = LN_W'(LINES);
    end else begin
      stop_lim = LN_W'(in_stop_line);
    end
  end

  // Sequencer: next state, store access and result generation.
  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_end_nxt  = sweep_end_r;
    phase_nxt      = phase_r;
    ln_nxt         = ln_r;
    slot_nxt       = slot_r;
    frm_addr_nxt   = frm_addr_r;
    store_req.we    = 1'b0;
    store_req.waddr = '0;
    store_req.wdata = BYTE_ZERO;
    store_req.raddr = frm_addr_r;
    load    = 1'b0;
    ld_byte = BYTE_ZERO;
    ld_fs   = 1'b0;
    ld_last = 1'b0;

    unique case (state_r)
      ST_SWEEP: begin
        // Zero one store byte per cycle.
        store_req.we    = 1'b1;
        store_req.waddr = sweep_addr_r[ADDR_W-1:0];
        if (sweep_addr_r == sweep_end_r - CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_WRITE: begin
              if (wr_in_range) begin
                store_req.we    = 1'b1;
                store_req.waddr = wr_addr;
                store_req.wdata = in_data;
              end
            end
            CMD_CLEAR_ALL: begin
              state_nxt      = ST_CLR_HEAD;
              sweep_addr_nxt = '0;
              sweep_end_nxt  = CNT_W'(STORE_DEPTH);
              phase_nxt      = PH_HEAD;
              ln_nxt         = '0;
              slot_nxt       = '0;
              frm_addr_nxt   = '0;
            end
            CMD_CLEAR_RANGE: begin
              if (int'(in_line) < int'(stop_lim)) begin
                state_nxt      = ST_SWEEP;
                sweep_addr_nxt = CNT_W'(int'(in_line) * BYTES_PER_LINE);
                sweep_end_nxt  = CNT_W'(int'(stop_lim) * BYTES_PER_LINE);
              end
            end
            CMD_TICK: begin
              state_nxt = ST_TICK;
            end
          endcase
        end
      end

      ST_TICK: begin
        // The registered read holds the store byte at the frame address.
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          unique case (phase_r)
            PH_HEAD: begin
              ld_byte      = BYTE_UPDATE;
              ld_fs        = 1'b1;
              phase_nxt    = PH_BODY;
              ln_nxt       = '0;
              slot_nxt     = '0;
              frm_addr_nxt = '0;
            end
            PH_BODY: begin
              if (slot_r == '0) begin
                ld_byte = mirror8(8'(ln_r) + 8'd1);
              end else if (int'(slot_r) <= BYTES_PER_LINE) begin
                ld_byte      = ~store_rdata;
                frm_addr_nxt = frm_addr_r + ADDR_W'(1);
              end else begin
                ld_byte = BYTE_ZERO;
              end
              if (slot_r == SLOT_W'(BYTES_PER_LINE + 1)) begin
                slot_nxt = '0;
                if (ln_r == LN_W'(LINES - 1)) begin
                  phase_nxt = PH_TAIL;
                end else begin
                  ln_nxt = ln_r + LN_W'(1);
                end
              end else begin
                slot_nxt = slot_r + SLOT_W'(1);
              end
            end
            PH_TAIL: begin
              ld_byte   = BYTE_ZERO;
              ld_last   = 1'b1;
              phase_nxt = PH_HEAD;
            end
            default: begin
              phase_nxt = PH_HEAD;
            end
          endcase
        end
      end

      ST_CLR_HEAD: begin
        if (out_free) begin
          load      = 1'b1;
          ld_byte   = BYTE_CLEAR;
          ld_fs     = 1'b1;
          state_nxt = ST_CLR_TAIL;
        end
      end

      ST_CLR_TAIL: begin
        // The sweep bounds were set when the clear was taken.
        if (out_free) begin
          load      = 1'b1;
          ld_byte   = BYTE_ZERO;
          ld_last   = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  // Control registers; the store is cleared by a sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_addr_r <= '0;
      sweep_end_r  <= CNT_W'(STORE_DEPTH);
      phase_r      <= PH_HEAD;
      ln_r         <= '0;
      slot_r       <= '0;
      frm_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_end_r  <= sweep_end_nxt;
      phase_r      <= phase_nxt;
      ln_r         <= ln_nxt;
      slot_r       <= slot_nxt;
      frm_addr_r   <= frm_addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= ld_byte;
      out_fs_r   <= ld_fs;
      out_last_r <= ld_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_spi_byte    = out_byte_r;
  assign out_frame_start = out_fs_r;
  assign out_last        = out_last_r;

endmodule

### src/memory_lcd_frame_update.sv
// Frame store of 96 lines by 12 bytes with a byte-serial refresh stream for a
// memory LCD. A byte write is taken without stalling the input. A refresh
// tick gives one word: the store byte is read through the registered
// read port of the store and then formatted. Clear all gives its two
// words, then zeroes the store at one byte per cycle; a clear range
// likewise zeroes the bytes of its lines, both paced by the one write port of
// the store. After reset the block runs a clearing pass over the whole store
// before it takes its first word. A finished word waits in the output
// register while the next input word is taken.
module memory_lcd_frame_update import mlcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [6:0] in_line,
  input  logic [3:0] in_column,
  input  logic [7:0] in_data,
  input  logic [6:0] in_stop_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_spi_byte,
  output logic       out_frame_start,
  output logic       out_last
);

  store_req_t store_req;
  logic [7:0] store_rdata;

  mlcd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_line         (in_line),
    .in_column       (in_column),
    .in_data         (in_data),
    .in_stop_line    (in_stop_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_spi_byte    (out_spi_byte),
    .out_frame_start (out_frame_start),
    .out_last        (out_last),
    .store_req       (store_req),
    .store_rdata     (store_rdata)
  );

  mlcd_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

endmodule

### src/mlcd_checker.sv
module mlcd_checker import mlcd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_spi_byte,
  input logic       out_frame_start,
  input logic       out_last
);

  // A stalled output word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_spi_byte) &&
      $stable(out_frame_start) && $stable(out_last))
    else $error("stalled output word changed");

  // The clearing pass keeps the input stalled right after reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("input taken during the clearing pass");

  // A tick or a clear all occupies the sequencer in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
      (in_command == CMD_TICK || in_command == CMD_CLEAR_ALL) |=> in_stall)
    else $error("sequencer free too early");

  // A byte write leaves the input free in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_WRITE |=> !in_stall)
    else $error("byte write held the input");

  // No word both opens and closes a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_start && out_last))
    else $error("word marked as both frame start and last");

endmodule

bind memory_lcd_frame_update mlcd_checker u_mlcd_checker (.*);

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlcd_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 9;
  localparam int SLOT_LEN     = BYTES_PER_LINE + 2;
  localparam int FRAME_LEN    = 2 + LINES * SLOT_LEN;
  localparam int RANDOM_WORDS = 675;
  localparam int HOLD_AT      = 40;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 1300;

  // One input word and one serial word, at the widths of the ports.
  typedef struct packed {
    cmd_t       command;
    logic [6:0] line;
    logic [3:0] column;
    logic [7:0] data;
    logic [6:0] stop_line;
  } in_word_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_start;
    logic       last;
  } spi_word_t;

  // A directed word, with up to two serial words typed in by hand.
  typedef struct {
    in_word_t  w;
    int        n_typed;
    spi_word_t t0;
    spi_word_t t1;
  } directed_row_t;

  localparam spi_word_t NO_WORD = '{8'h00, 1'b0, 1'b0};
  localparam spi_word_t OPEN_WD = '{BYTE_UPDATE, 1'b1, 1'b0};
  localparam spi_word_t LINE1_WD = '{8'h80, 1'b0, 1'b0};
  localparam spi_word_t BLANK_WD = '{8'hFF, 1'b0, 1'b0};
  localparam spi_word_t CLR_HEAD = '{BYTE_CLEAR, 1'b1, 1'b0};
  localparam spi_word_t CLR_TAIL = '{BYTE_ZERO, 1'b0, 1'b1};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_WRITE;
  logic [6:0] in_line = '0;
  logic [3:0] in_column = '0;
  logic [7:0] in_data = '0;
  logic [6:0] in_stop_line = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_spi_byte;
  logic       out_frame_start;
  logic       out_last;

  // Model of the panel: its pixel bytes and the next byte of the refresh frame.
  logic [7:0]  pixel_mem [STORE_DEPTH];
  int unsigned frame_pos;
  spi_word_t   spi_expected [$];
  int          fault_count = 0;
  int          bytes_taken = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  directed_row_t directed_rows [25] = '{
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   1, OPEN_WD,  NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   1, LINE1_WD, NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   1, BLANK_WD, NO_WORD},
    '{'{CMD_WRITE,       7'd0,   4'd1,  8'h00, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_WRITE,       7'd95,  4'd11, 8'hFF, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_WRITE,       7'd0,   4'd2,  8'hA5, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_WRITE,       7'd96,  4'd0,  8'h55, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_WRITE,       7'd127, 4'd15, 8'hFF, 7'd127}, 0, NO_WORD,  NO_WORD},
    '{'{CMD_WRITE,       7'd0,   4'd12, 8'h3C, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_RANGE, 7'd0,   4'd0,  8'h00, 7'd1},   0, NO_WORD,  NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_RANGE, 7'd50,  4'd0,  8'h00, 7'd10},  0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_RANGE, 7'd5,   4'd0,  8'h00, 7'd5},   0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_RANGE, 7'd90,  4'd0,  8'h00, 7'd127}, 0, NO_WORD,  NO_WORD},
    '{'{CMD_WRITE,       7'd0,   4'd4,  8'h7E, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_ALL,   7'd0,   4'd0,  8'h00, 7'd0},   2, CLR_HEAD, CLR_TAIL},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   1, OPEN_WD,  NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   1, LINE1_WD, NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   1, BLANK_WD, NO_WORD},
    '{'{CMD_WRITE,       7'd95,  4'd11, 8'h81, 7'd0},   0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_RANGE, 7'd127, 4'd0,  8'h00, 7'd127}, 0, NO_WORD,  NO_WORD},
    '{'{CMD_CLEAR_RANGE, 7'd0,   4'd0,  8'h00, 7'd96},  0, NO_WORD,  NO_WORD},
    '{'{CMD_TICK,        7'd0,   4'd0,  8'h00, 7'd0},   0, NO_WORD,  NO_WORD}
  };

  memory_lcd_frame_update u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_line         (in_line),
    .in_column       (in_column),
    .in_data         (in_data),
    .in_stop_line    (in_stop_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_spi_byte    (out_spi_byte),
    .out_frame_start (out_frame_start),
    .out_last        (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror the eight bits of a line address.
  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  // Wait drawn per word; a calm stretch has no idling at all.
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Line whose bytes the next few ticks will read.
  function automatic int unsigned line_in_flight();
    if (frame_pos == 0 || frame_pos >= FRAME_LEN - 1) begin
      return 0;
    end
    return (frame_pos - 1) / SLOT_LEN;
  endfunction

  // Apply one word to the panel model and give the serial words it causes.
  task automatic panel_step(input in_word_t w, output int n, output spi_word_t r0,
                            output spi_word_t r1);
    int unsigned q, ln, k, stop;
    n  = 0;
    r0 = NO_WORD;
    r1 = NO_WORD;
    case (w.command)
      CMD_WRITE: begin
        if (w.line < LINES && w.column < BYTES_PER_LINE) begin
          pixel_mem[w.line * BYTES_PER_LINE + w.column] = w.data;
        end
      end
      CMD_CLEAR_ALL: begin
        foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
        frame_pos = 0;
        n  = 2;
        r0 = CLR_HEAD;
        r1 = CLR_TAIL;
      end
      CMD_CLEAR_RANGE: begin
        stop = (w.stop_line > LINES) ? LINES : w.stop_line;
        for (int unsigned l = w.line; l < stop; l++) begin
          for (int c = 0; c < BYTES_PER_LINE; c++) pixel_mem[l * BYTES_PER_LINE + c] = 8'h00;
        end
      end
      default: begin
        n = 1;
        if (frame_pos == 0) begin
          r0 = OPEN_WD;
        end else if (frame_pos >= FRAME_LEN - 1) begin
          r0 = CLR_TAIL;
        end else begin
          q  = frame_pos - 1;
          ln = q / SLOT_LEN;
          k  = q % SLOT_LEN;
          if (k == 0) begin
            r0.spi_byte = flip_bits(8'(ln + 1));
          end else if (k <= BYTES_PER_LINE) begin
            r0.spi_byte = ~pixel_mem[ln * BYTES_PER_LINE + k - 1];
          end else begin
            r0.spi_byte = BYTE_ZERO;
          end
        end
        frame_pos = (frame_pos + 1 >= FRAME_LEN) ? 0 : frame_pos + 1;
      end
    endcase
  endtask

  task automatic post_expected(input int n, input spi_word_t r0, input spi_word_t r1);
    if (n > 0) spi_expected.push_back(r0);
    if (n > 1) spi_expected.push_back(r1);
  endtask

  // Random word, mostly ticks and writes with the odd clear.
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.command   = CMD_TICK;
    w.line      = 7'($urandom_range(0, 127));
    w.column    = 4'($urandom_range(0, 15));
    w.data      = 8'($urandom);
    w.stop_line = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick >= 55 && pick < 85) begin
      w.command = CMD_WRITE;
      // Half the time aim at the line being sent, so reads see fresh bytes.
      if ($urandom_range(0, 1) == 0) begin
        w.line = 7'(line_in_flight());
      end else if ($urandom_range(0, 15) != 0) begin
        w.line = 7'($urandom_range(0, LINES - 1));
      end
      if ($urandom_range(0, 15) != 0) w.column = 4'($urandom_range(0, BYTES_PER_LINE - 1));
    end else if (pick >= 85 && pick < 96) begin
      w.command = CMD_CLEAR_RANGE;
      if ($urandom_range(0, 7) != 0) begin
        w.line      = 7'($urandom_range(0, LINES - 1));
        w.stop_line = 7'(w.line + $urandom_range(0, 3));
      end
    end else if (pick >= 96) begin
      w.command = CMD_CLEAR_ALL;
    end
    return w;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = draw_gap(tx_calm);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= w.command;
    in_line      <= w.line;
    in_column    <= w.column;
    in_data      <= w.data;
    in_stop_line <= w.stop_line;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stimulus: directed rows, then random words.
  initial begin : stimulus
    in_word_t  w;
    int        n;
    spi_word_t r0, r1;
    foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
    frame_pos = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].w);
      panel_step(directed_rows[i].w, n, r0, r1);
      if (directed_rows[i].n_typed != 0) begin
        n  = directed_rows[i].n_typed;
        r0 = directed_rows[i].t0;
        r1 = directed_rows[i].t1;
      end
      post_expected(n, r0, r1);
    end

    repeat (RANDOM_WORDS) begin
      w = random_word();
      send_word(w);
      panel_step(w, n, r0, r1);
      post_expected(n, r0, r1);
    end
    in_valid <= 1'b0;

    // Let the last words drain, then watch for strays while any clear finishes.
    while (spi_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and a field check on every word.
  initial begin : spi_monitor
    spi_word_t want;
    int        hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = (bytes_taken == HOLD_AT) ? LONG_HOLD : draw_gap(rx_calm);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      bytes_taken++;
      if (spi_expected.size() == 0) begin
        $error("unexpected word: spi_byte %h frame_start %b last %b",
               out_spi_byte, out_frame_start, out_last);
        fault_count++;
      end else begin
        want = spi_expected.pop_front();
        if (out_spi_byte !== want.spi_byte) begin
          $error("spi_byte: expected %h, got %h", want.spi_byte, out_spi_byte);
          fault_count++;
        end
        if (out_frame_start !== want.frame_start) begin
          $error("frame_start: expected %b, got %b", want.frame_start, out_frame_start);
          fault_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_last);
          fault_count++;
        end
      end
    end
  end

  // Watchdog for a block that hangs.
  initial begin : watchdog
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
src/mlcd_pkg.sv
src/mlcd_store.sv
src/mlcd_ctrl.sv
src/memory_lcd_frame_update.sv
src/mlcd_checker.sv
sim/tb.sv
